// ===== hw/rtl/sale_pkg.sv =====
// types and constants shared by the level estimator controller and datapath
// no dependencies
`timescale 1ns / 1ps

package sale_pkg;

  typedef enum logic [4:0] {
    S_IDLE, S_ACC, S_DLOG_LD, S_DLOG, S_DMUL, S_DISP,
    S_SQA_LD, S_SQA, S_AGC, S_SQD_LD, S_SQD, S_DAC,
    S_TLOG_LD, S_TLOG, S_TMUL, S_SIG, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    REG_BAND_LOW, REG_BAND_HIGH, REG_NCO, REG_LEVEL_SEL,
    REG_SMOOTH, REG_CW_LOW, REG_CW_HIGH
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_CW, MODE_NCO, MODE_BAND, MODE_PEAK
  } level_sel_t;

  localparam int POW_W  = 15;
  localparam int LVL_W  = 16;
  localparam int SIG_W  = 9;
  localparam int CW_W   = 21;
  localparam int NCO_W  = 18;
  localparam int BAND_W = 23;

  localparam logic [18:0] LOG_K       = 19'd454261;
  localparam logic [22:0] RMS_LIMIT   = 23'd160000;
  localparam logic [31:0] RMS_SCALE   = 32'd25600;
  localparam logic signed [17:0] DB_ZERO   = -18'sd11796;
  localparam logic signed [17:0] DB_OFFSET = 18'sd5888;
  localparam logic [3:0] LAST_STEP = 4'd15;

  typedef struct packed {
    logic capture;
    logic acc;
    logic log_load;
    logic log_total;
    logic log_step;
    logic log_mul;
    logic disp_update;
    logic sq_load;
    logic sq_peak;
    logic sq_step;
    logic agc_update;
    logic dac_update;
    logic sig_update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic upd;
    logic last;
    logic log_done;
    logic sq_done;
    logic out_busy;
  } stat_t;

endpackage

// ===== hw/rtl/sale_ctrl.sv =====
// sequencer for the level estimator: one bin at a time through log, sqrt and smoothing
// depends on sale_pkg
`timescale 1ns / 1ps

module sale_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sale_pkg::stat_t stat,
  output sale_pkg::cmd_t  cmd
);
  import sale_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_ACC;
      S_ACC: begin
        if (stat.upd) state_next = S_DLOG_LD;
        else if (stat.last) state_next = S_SQA_LD;
        else state_next = S_OUT;
      end
      S_DLOG_LD: state_next = S_DLOG;
      S_DLOG:    if (stat.log_done) state_next = S_DMUL;
      S_DMUL:    state_next = S_DISP;
      S_DISP:    state_next = stat.last ? S_SQA_LD : S_OUT;
      S_SQA_LD:  state_next = S_SQA;
      S_SQA:     if (stat.sq_done) state_next = S_AGC;
      S_AGC:     state_next = S_SQD_LD;
      S_SQD_LD:  state_next = S_SQD;
      S_SQD:     if (stat.sq_done) state_next = S_DAC;
      S_DAC:     state_next = S_TLOG_LD;
      S_TLOG_LD: state_next = S_TLOG;
      S_TLOG:    if (stat.log_done) state_next = S_TMUL;
      S_TMUL:    state_next = S_SIG;
      S_SIG:     state_next = S_OUT;
      S_OUT:     if (!stat.out_busy) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE:    cmd.capture = in_valid;
      S_ACC:     cmd.acc = 1'b1;
      S_DLOG_LD: cmd.log_load = 1'b1;
      S_DLOG:    cmd.log_step = 1'b1;
      S_DMUL:    cmd.log_mul = 1'b1;
      S_DISP:    cmd.disp_update = 1'b1;
      S_SQA_LD:  cmd.sq_load = 1'b1;
      S_SQA:     cmd.sq_step = 1'b1;
      S_AGC:     cmd.agc_update = 1'b1;
      S_SQD_LD: begin
        cmd.sq_load = 1'b1;
        cmd.sq_peak = 1'b1;
      end
      S_SQD:     cmd.sq_step = 1'b1;
      S_DAC:     cmd.dac_update = 1'b1;
      S_TLOG_LD: begin
        cmd.log_load = 1'b1;
        cmd.log_total = 1'b1;
      end
      S_TLOG:    cmd.log_step = 1'b1;
      S_TMUL:    cmd.log_mul = 1'b1;
      S_SIG:     cmd.sig_update = 1'b1;
      S_OUT:     cmd.out_load = !stat.out_busy;
      default:   cmd = '0;
    endcase
  end

  // scaling multiply only after the last squaring step
  a_mul_after_log: assert property (@(posedge clk) disable iff (rst)
    cmd.log_mul |-> $past(cmd.log_step) && $past(stat.log_done))
    else $error("log multiply without finished iterations");

  a_capture_to_acc: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_ACC)
    else $error("captured bin not accumulated");

  a_sqrt_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.agc_update || cmd.dac_update) |-> $past(stat.sq_done))
    else $error("rms update before sqrt finished");

endmodule

// ===== hw/rtl/sale_datapath.sv =====
// datapath: config registers, display store, frame sums, log and sqrt units, output register
// depends on sale_pkg
`timescale 1ns / 1ps

module sale_datapath #(
  parameter int NUM_BINS = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sale_pkg::cmd_t               cmd,
  output sale_pkg::stat_t              stat,
  input  logic [7:0]                   bin_number,
  input  logic [sale_pkg::POW_W-1:0]   bin_power,
  input  logic                         cfg_write_en,
  input  logic [2:0]                   cfg_index,
  input  logic [15:0]                  cfg_data,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [7:0]                   out_bin,
  output logic [sale_pkg::LVL_W-1:0]   display_level,
  output logic                         frame_done,
  output logic [sale_pkg::LVL_W-1:0]   agc_level,
  output logic [sale_pkg::LVL_W-1:0]   dac_agc_level,
  output logic signed [sale_pkg::SIG_W-1:0] signal_level
);
  import sale_pkg::*;

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int CMP_W = IDX_W + 4;

  function automatic logic [15:0] smooth16(input logic [15:0] c, input logic [15:0] x,
                                            input logic [15:0] old);
    logic [33:0] a;
    a = 34'(c) * 34'(x) + 34'(17'h10000 - {1'b0, c}) * 34'(old) + 34'd32768;
    return a[31:16];
  endfunction

  // configuration
  logic [7:0]  band_low_bin, band_high_bin, nco_bin, cw_low_bin, cw_high_bin;
  logic [1:0]  level_sel;
  logic [15:0] smooth_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_low_bin  <= 8'd0;
      band_high_bin <= 8'd255;
      nco_bin       <= 8'd64;
      level_sel     <= MODE_CW;
      smooth_coeff  <= 16'd13107;
      cw_low_bin    <= 8'd25;
      cw_high_bin   <= 8'd51;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_BAND_LOW:  band_low_bin  <= cfg_data[7:0];
        REG_BAND_HIGH: band_high_bin <= cfg_data[7:0];
        REG_NCO:       nco_bin       <= cfg_data[7:0];
        REG_LEVEL_SEL: level_sel     <= cfg_data[1:0];
        REG_SMOOTH:    smooth_coeff  <= cfg_data;
        REG_CW_LOW:    cw_low_bin    <= cfg_data[7:0];
        REG_CW_HIGH:   cw_high_bin   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [7:0]       b_reg;
  logic [POW_W-1:0] p_reg;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      b_reg <= bin_number;
      p_reg <= bin_power;
    end
  end

  logic [CMP_W-1:0] bext, cwl, cwh, bdl, bdh, nco;
  logic in_range, upd, last, cw_hit, band_hit, nco_hit;
  logic [IDX_W-1:0] idx;

  assign bext = {{(CMP_W-8){1'b0}}, b_reg};
  assign cwl  = {{(CMP_W-8){1'b0}}, cw_low_bin};
  assign cwh  = {{(CMP_W-8){1'b0}}, cw_high_bin};
  assign bdl  = {{(CMP_W-8){1'b0}}, band_low_bin};
  assign bdh  = {{(CMP_W-8){1'b0}}, band_high_bin};
  assign nco  = {{(CMP_W-8){1'b0}}, nco_bin};
  assign idx  = bext[IDX_W-1:0];

  assign in_range = bext < CMP_W'(NUM_BINS);
  assign upd      = in_range && bext >= CMP_W'(8) && bext < CMP_W'(NUM_BINS - 4);
  assign last     = bext == CMP_W'(NUM_BINS - 1);
  assign cw_hit   = bext >= cwl && bext <= cwh;
  assign band_hit = bext >= bdl && bext <= bdh;
  assign nco_hit  = nco >= CMP_W'(8) && nco < CMP_W'(NUM_BINS - 4) &&
                    bext + CMP_W'(2) >= nco && bext <= nco + CMP_W'(2);

  // display store, valid bits stand in for the all-zero reset
  logic [LVL_W-1:0]    store [NUM_BINS];
  logic [NUM_BINS-1:0] vbits;
  logic [LVL_W-1:0]    rd_data, old_disp, dnew;
  logic                rd_vld;
  logic [LVL_W-1:0]    log_res;

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      rd_data <= store[idx];
      rd_vld  <= vbits[idx] && in_range;
    end
    if (cmd.disp_update) begin
      store[idx] <= smooth16(smooth_coeff, log_res, old_disp);
      dnew       <= smooth16(smooth_coeff, log_res, old_disp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (cmd.disp_update) begin
      vbits[idx] <= 1'b1;
    end
  end

  assign old_disp = rd_vld ? rd_data : '0;

  // frame sums, saturating
  logic [CW_W-1:0]   cw_sum;
  logic [NCO_W-1:0]  nco_sum;
  logic [BAND_W-1:0] band_sum;
  logic [POW_W-1:0]  band_peak;
  logic [CW_W:0]     cw_add;
  logic [NCO_W:0]    nco_add;
  logic [BAND_W:0]   band_add;

  assign cw_add   = {1'b0, cw_sum} + (CW_W+1)'(p_reg);
  assign nco_add  = {1'b0, nco_sum} + (NCO_W+1)'(p_reg);
  assign band_add = {1'b0, band_sum} + (BAND_W+1)'(p_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      cw_sum    <= '0;
      nco_sum   <= '0;
      band_sum  <= '0;
      band_peak <= '0;
    end else if (cmd.out_load && last) begin
      cw_sum    <= '0;
      nco_sum   <= '0;
      band_sum  <= '0;
      band_peak <= '0;
    end else if (cmd.acc) begin
      if (upd && cw_hit) cw_sum <= cw_add[CW_W] ? '1 : cw_add[CW_W-1:0];
      if (upd && band_hit) begin
        band_sum <= band_add[BAND_W] ? '1 : band_add[BAND_W-1:0];
        if (p_reg > band_peak) band_peak <= p_reg;
      end
      if (in_range && nco_hit) nco_sum <= nco_add[NCO_W] ? '1 : nco_add[NCO_W-1:0];
    end
  end

  logic [BAND_W-1:0] total;
  logic total_ok;

  always_comb begin
    case (level_sel)
      MODE_CW:   total = BAND_W'(cw_sum);
      MODE_NCO:  total = BAND_W'(nco_sum);
      MODE_BAND: total = band_sum;
      default:   total = BAND_W'(band_peak);
    endcase
  end

  assign total_ok = total < RMS_LIMIT;

  // log2 unit: leading one, then one squaring step per cycle
  logic [BAND_W-1:0] log_x;
  logic [18:0]       p10;
  logic [4:0]        e_c, le;
  logic [31:0]       lm;
  logic [15:0]       lfrac;
  logic [3:0]        lcnt;
  logic [52:0]       lsh;
  logic [63:0]       lsq;
  logic [33:0]       lt;
  logic [39:0]       lprod;

  assign p10   = {1'b0, p_reg, 3'b0} + {3'b0, p_reg, 1'b0} + 19'd1;
  assign log_x = cmd.log_total ? total : BAND_W'(p10);

  always_comb begin
    e_c = '0;
    for (int i = 1; i < BAND_W; i++) begin
      if (log_x[i]) e_c = 5'(i);
    end
  end

  assign lsh   = {log_x, 30'b0} >> e_c;
  assign lsq   = 64'(lm) * 64'(lm);
  assign lt    = lsq[63:30];
  assign lprod = 40'({le, lfrac}) * 40'(LOG_K) + 40'h800000;

  always_ff @(posedge clk) begin
    if (cmd.log_load) begin
      lm    <= lsh[31:0];
      le    <= e_c;
      lfrac <= '0;
      lcnt  <= '0;
    end else if (cmd.log_step) begin
      lm    <= lt[31] ? lt[32:1] : lt[31:0];
      lfrac <= {lfrac[14:0], lt[31]};
      lcnt  <= lcnt + 4'd1;
    end
    if (cmd.log_mul) log_res <= lprod[39:24];
  end

  // bit-pair square root, one result bit per cycle
  logic [31:0] sv, sr, sbit;
  logic [3:0]  scnt;
  logic [32:0] strial;

  assign strial = {1'b0, sr} + {1'b0, sbit};

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      if (cmd.sq_peak) sv <= 32'(band_peak) * RMS_SCALE;
      else if (total_ok) sv <= 32'(total[17:0]) * RMS_SCALE;
      else sv <= '0;
      sr   <= '0;
      sbit <= 32'h4000_0000;
      scnt <= '0;
    end else if (cmd.sq_step) begin
      if ({1'b0, sv} >= strial) begin
        sv <= sv - strial[31:0];
        sr <= (sr >> 1) + sbit;
      end else begin
        sr <= sr >> 1;
      end
      sbit <= sbit >> 2;
      scnt <= scnt + 4'd1;
    end
  end

  // smoothed levels
  logic [LVL_W-1:0]        agc_reg, dac_reg;
  logic signed [SIG_W-1:0] sig_reg;
  logic signed [17:0]      db, ci;
  logic signed [16:0]      cs, olds;
  logic signed [35:0]      acc, acc_r;
  logic signed [11:0]      q;
  logic signed [SIG_W-1:0] sig_c;

  assign db   = (total == '0) ? DB_ZERO : DB_OFFSET + $signed({2'b0, log_res});
  assign cs   = $signed({1'b0, smooth_coeff});
  assign ci   = $signed(18'h10000 - {2'b0, smooth_coeff});
  assign olds = $signed({sig_reg, 8'b0});
  assign acc  = cs * db + ci * olds;
  // truncate toward zero
  assign acc_r = (acc < 0) ? acc + 36'sd16777215 : acc;
  assign q     = 12'(acc_r >>> 24);

  always_comb begin
    if (q > 12'sd255) sig_c = 9'sd255;
    else if (q < -12'sd256) sig_c = -9'sd256;
    else sig_c = q[SIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      agc_reg <= '0;
      dac_reg <= '0;
      sig_reg <= '0;
    end else begin
      if (cmd.agc_update && total_ok) agc_reg <= smooth16(smooth_coeff, sr[15:0], agc_reg);
      if (cmd.dac_update) dac_reg <= smooth16(smooth_coeff, sr[15:0], dac_reg);
      if (cmd.sig_update) sig_reg <= sig_c;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_bin       <= b_reg;
      display_level <= upd ? dnew : old_disp;
      frame_done    <= last;
      agc_level     <= last ? agc_reg : '0;
      dac_agc_level <= last ? dac_reg : '0;
      signal_level  <= last ? sig_reg : '0;
    end
  end

  assign stat.upd      = upd;
  assign stat.last     = last;
  assign stat.log_done = lcnt == LAST_STEP;
  assign stat.sq_done  = scnt == LAST_STEP;
  assign stat.out_busy = out_valid && out_stall;

endmodule

// ===== hw/rtl/spectrum_agc_level_estimator.sv =====
// top level of the spectrum display and agc level estimator
// depends on sale_pkg, sale_ctrl, sale_datapath
//
//   port group   direction  handshake             payload
//   in           to block   in_valid / in_stall   bin_number, bin_power
//   out          from block out_valid / out_stall display_level, levels, frame_done
//   cfg          to block   cfg_write_en          cfg_index, cfg_data
//
// one bin at a time: bins outside the display range go straight to the output register,
// display bins run the 16-step log squaring loop, and the last bin of a frame runs
// two 16-step sqrt passes on the shared root unit plus one log pass.
// reset is synchronous; display store entries read as zero until written, no clearing pass.
// a new bin is taken while the previous result waits in the output register.
`timescale 1ns / 1ps

module spectrum_agc_level_estimator #(
  parameter int NUM_BINS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        bin_number,
  input  logic [sale_pkg::POW_W-1:0]        bin_power,
  input  logic                              cfg_write_en,
  input  logic [2:0]                        cfg_index,
  input  logic [15:0]                       cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_bin,
  output logic [sale_pkg::LVL_W-1:0]        display_level,
  output logic                              frame_done,
  output logic [sale_pkg::LVL_W-1:0]        agc_level,
  output logic [sale_pkg::LVL_W-1:0]        dac_agc_level,
  output logic signed [sale_pkg::SIG_W-1:0] signal_level
);
  import sale_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sale_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sale_datapath #(
    .NUM_BINS (NUM_BINS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .bin_number    (bin_number),
    .bin_power     (bin_power),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_bin       (out_bin),
    .display_level (display_level),
    .frame_done    (frame_done),
    .agc_level     (agc_level),
    .dac_agc_level (dac_agc_level),
    .signal_level  (signal_level)
  );

endmodule
